/* rtl/reorderable_pending_queue_assert.svh */
// assertion macros for the reorderable pending queue checker
`ifndef REORDERABLE_PENDING_QUEUE_ASSERT_SVH
`define REORDERABLE_PENDING_QUEUE_ASSERT_SVH

// consequent must hold on the clock after the antecedent
`define RPQ_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rpq assertion failed");

// consequent must hold on the same clock as the antecedent
`define RPQ_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rpq assertion failed");

`endif

/* rtl/rpq_pkg.sv */
// types and constants shared by the reorderable pending queue modules
package rpq_pkg;

   typedef enum logic [3:0] {
      MODE_LOAD     = 4'd0,
      MODE_MOVE     = 4'd1,
      MODE_UP       = 4'd2,
      MODE_DOWN     = 4'd3,
      MODE_REMOVE   = 4'd4,
      MODE_ACQUIRE  = 4'd5,
      MODE_COMPLETE = 4'd6,
      MODE_RELEASE  = 4'd7,
      MODE_READ     = 4'd8
   } mode_type;

   typedef struct packed {
      logic [3:0]  mode;
      logic [63:0] file_id;
      logic [47:0] file_size;
      logic [5:0]  dest_index;
   } req_type;

   typedef struct packed {
      logic        ok;
      logic [63:0] out_id;
      logic [47:0] out_size;
      logic [6:0]  pending_count;
      logic        active_valid;
      logic [63:0] active_id;
      logic [53:0] bytes_held;
      logic [6:0]  files_held;
   } rsp_type;

   typedef struct packed {
      logic [63:0] id;
      logic [47:0] size;
   } entry_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_FIND,
      ST_CHECK,
      ST_ROT,
      ST_ROT_WR,
      ST_FIN,
      ST_DONE
   } ctl_state_type;

   typedef struct packed {
      logic lat_req;
      logic scan_clr;
      logic scan_inc;
      logic rd_scan;
      logic find_setup;
      logic rel_setup;
      logic rd_rot;
      logic rot_wr;
      logic fin_wr;
      logic do_load;
      logic do_complete;
      logic set_ok;
      logic rsp_load;
   } cmd_type;

   typedef struct packed {
      logic [3:0] mode;
      logic       load_ok;
      logic       slot_match;
      logic       cnt_full;
      logic       idx_ok;
      logic       scan_end;
      logic       found;
      logic       find_ok;
      logic       at_end;
      logic       rsp_free;
   } sts_type;

endpackage

/* rtl/rpq_ctrl.sv */
// sequencing state machine of the reorderable pending queue
module rpq_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  rpq_pkg::sts_type sts,
   output rpq_pkg::cmd_type cmd
);

   rpq_pkg::ctl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rpq_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rpq_pkg::ST_IDLE: begin
            if (req_valid) state_in = rpq_pkg::ST_DECODE;
         end
         rpq_pkg::ST_DECODE: begin
            case (sts.mode)
               rpq_pkg::MODE_RELEASE: begin
                  state_in = (sts.slot_match && !sts.cnt_full) ? rpq_pkg::ST_ROT
                                                               : rpq_pkg::ST_DONE;
               end
               rpq_pkg::MODE_READ: begin
                  state_in = sts.idx_ok ? rpq_pkg::ST_FIND : rpq_pkg::ST_DONE;
               end
               rpq_pkg::MODE_MOVE, rpq_pkg::MODE_UP, rpq_pkg::MODE_DOWN,
               rpq_pkg::MODE_REMOVE, rpq_pkg::MODE_ACQUIRE: begin
                  state_in = rpq_pkg::ST_FIND;
               end
               default: state_in = rpq_pkg::ST_DONE;
            endcase
         end
         rpq_pkg::ST_FIND: begin
            state_in = sts.scan_end ? rpq_pkg::ST_DONE : rpq_pkg::ST_CHECK;
         end
         rpq_pkg::ST_CHECK: begin
            if (!sts.found) begin
               state_in = rpq_pkg::ST_FIND;
            end else if (!sts.find_ok || sts.mode == rpq_pkg::MODE_READ) begin
               state_in = rpq_pkg::ST_DONE;
            end else begin
               state_in = rpq_pkg::ST_ROT;
            end
         end
         rpq_pkg::ST_ROT: begin
            state_in = sts.at_end ? rpq_pkg::ST_FIN : rpq_pkg::ST_ROT_WR;
         end
         rpq_pkg::ST_ROT_WR: state_in = rpq_pkg::ST_ROT;
         rpq_pkg::ST_FIN:    state_in = rpq_pkg::ST_DONE;
         rpq_pkg::ST_DONE: begin
            if (sts.rsp_free) state_in = rpq_pkg::ST_IDLE;
         end
         default: state_in = rpq_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         rpq_pkg::ST_IDLE: begin
            req_ready   = !reset;
            cmd.lat_req = req_valid && !reset;
         end
         rpq_pkg::ST_DECODE: begin
            cmd.scan_clr = 1'b1;
            case (sts.mode)
               rpq_pkg::MODE_LOAD: begin
                  cmd.do_load = sts.load_ok;
                  cmd.set_ok  = sts.load_ok;
               end
               rpq_pkg::MODE_COMPLETE: begin
                  cmd.do_complete = sts.slot_match;
                  cmd.set_ok      = sts.slot_match;
               end
               rpq_pkg::MODE_RELEASE: begin
                  cmd.rel_setup = sts.slot_match && !sts.cnt_full;
               end
               default: ;
            endcase
         end
         rpq_pkg::ST_FIND:  cmd.rd_scan = !sts.scan_end;
         rpq_pkg::ST_CHECK: begin
            cmd.scan_inc   = !sts.found;
            cmd.find_setup = sts.found && sts.find_ok;
            cmd.set_ok     = sts.found && sts.find_ok && sts.mode == rpq_pkg::MODE_READ;
         end
         rpq_pkg::ST_ROT:    cmd.rd_rot = !sts.at_end;
         rpq_pkg::ST_ROT_WR: cmd.rot_wr = 1'b1;
         rpq_pkg::ST_FIN: begin
            cmd.fin_wr = 1'b1;
            cmd.set_ok = 1'b1;
         end
         rpq_pkg::ST_DONE:   cmd.rsp_load = sts.rsp_free;
         default: ;
      endcase
   end

endmodule

/* rtl/rpq_dp.sv */
// entry memory, counters, active slot and result register of the queue
module rpq_dp #(
   parameter int DEPTH = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  rpq_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rpq_pkg::rsp_type rsp_data,
   input  rpq_pkg::cmd_type cmd,
   output rpq_pkg::sts_type sts
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int XW = (CW > 6) ? CW : 6;

   rpq_pkg::entry_type mem [DEPTH];
   rpq_pkg::entry_type rdata_ff, held_ff, slot_ff, slot_in, wdata;
   rpq_pkg::req_type   req_ff;
   rpq_pkg::rsp_type   rsp_ff;

   logic [CW-1:0] count_ff, count_in, scan_ff;
   logic [AW-1:0] cur_ff, tgt_ff, raddr, waddr, step_addr;
   logic          dir_up_ff, slot_valid_ff, slot_valid_in, ok_ff, rsp_valid_ff;
   logic [53:0]   bytes_ff, bytes_in;
   logic [6:0]    files_ff, files_in;
   logic          mem_we, mem_re, out_sel;

   // memory, single write and single registered read per cycle
   assign step_addr = dir_up_ff ? cur_ff + AW'(1) : cur_ff - AW'(1);
   assign raddr     = cmd.rd_scan ? scan_ff[AW-1:0] : step_addr;
   assign mem_re    = cmd.rd_scan | cmd.rd_rot;
   assign mem_we    = cmd.do_load | cmd.rot_wr | cmd.fin_wr;

   always_comb begin
      if (cmd.do_load) begin
         waddr = count_ff[AW-1:0];
         wdata = '{id: req_ff.file_id, size: req_ff.file_size};
      end else if (cmd.fin_wr) begin
         waddr = tgt_ff;
         wdata = held_ff;
      end else begin
         waddr = cur_ff;
         wdata = rdata_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[waddr] <= wdata;
      if (mem_re) rdata_ff <= mem[raddr];
   end

   // status towards the controller
   always_comb begin
      sts            = '0;
      sts.mode       = req_ff.mode;
      sts.load_ok    = ((CW+1)'(count_ff) + (CW+1)'(slot_valid_ff)) < (CW+1)'(DEPTH);
      sts.slot_match = slot_valid_ff && slot_ff.id == req_ff.file_id;
      sts.cnt_full   = count_ff == CW'(DEPTH);
      sts.idx_ok     = XW'(req_ff.dest_index) < XW'(count_ff);
      sts.scan_end   = scan_ff >= count_ff;
      sts.at_end     = cur_ff == tgt_ff;
      sts.rsp_free   = !rsp_valid_ff || rsp_ready;
      sts.found      = (req_ff.mode == rpq_pkg::MODE_ACQUIRE) ||
                       (req_ff.mode == rpq_pkg::MODE_READ) ||
                       (rdata_ff.id == req_ff.file_id);
      case (req_ff.mode)
         rpq_pkg::MODE_MOVE:    sts.find_ok = sts.idx_ok;
         rpq_pkg::MODE_UP:      sts.find_ok = scan_ff != '0;
         rpq_pkg::MODE_DOWN:    sts.find_ok = ((CW+1)'(scan_ff) + (CW+1)'(1)) <
                                              (CW+1)'(count_ff);
         rpq_pkg::MODE_REMOVE:  sts.find_ok = 1'b1;
         rpq_pkg::MODE_ACQUIRE: sts.find_ok = !slot_valid_ff;
         rpq_pkg::MODE_READ:    sts.find_ok = 1'b1;
         default:               sts.find_ok = 1'b0;
      endcase
   end

   // request, scan pointer and rotation registers
   always_ff @(posedge clock) begin
      if (cmd.lat_req) req_ff <= req_data;
      if (cmd.scan_clr) begin
         scan_ff <= (req_ff.mode == rpq_pkg::MODE_READ) ? CW'(req_ff.dest_index) : '0;
      end else if (cmd.scan_inc) begin
         scan_ff <= scan_ff + CW'(1);
      end
      if (cmd.find_setup) begin
         held_ff <= rdata_ff;
         cur_ff  <= scan_ff[AW-1:0];
         case (req_ff.mode)
            rpq_pkg::MODE_MOVE: begin
               tgt_ff    <= AW'(req_ff.dest_index);
               dir_up_ff <= scan_ff[AW-1:0] < AW'(req_ff.dest_index);
            end
            rpq_pkg::MODE_UP: begin
               tgt_ff    <= scan_ff[AW-1:0] - AW'(1);
               dir_up_ff <= 1'b0;
            end
            rpq_pkg::MODE_DOWN: begin
               tgt_ff    <= scan_ff[AW-1:0] + AW'(1);
               dir_up_ff <= 1'b1;
            end
            default: begin
               tgt_ff    <= AW'(count_ff - CW'(1));
               dir_up_ff <= 1'b1;
            end
         endcase
      end else if (cmd.rel_setup) begin
         held_ff   <= slot_ff;
         cur_ff    <= AW'(count_ff);
         tgt_ff    <= '0;
         dir_up_ff <= 1'b0;
      end else if (cmd.rot_wr) begin
         cur_ff <= step_addr;
      end
   end

   // queue count, active slot and running totals
   always_comb begin
      count_in      = count_ff;
      slot_in       = slot_ff;
      slot_valid_in = slot_valid_ff;
      bytes_in      = bytes_ff;
      files_in      = files_ff;
      if (cmd.do_load) begin
         count_in = count_ff + CW'(1);
         bytes_in = bytes_ff + 54'(req_ff.file_size);
         files_in = files_ff + 7'd1;
      end
      if (cmd.do_complete) begin
         slot_in       = '0;
         slot_valid_in = 1'b0;
      end
      if (cmd.fin_wr) begin
         case (req_ff.mode)
            rpq_pkg::MODE_REMOVE: begin
               count_in = count_ff - CW'(1);
               bytes_in = bytes_ff - 54'(held_ff.size);
               files_in = files_ff - 7'd1;
            end
            rpq_pkg::MODE_ACQUIRE: begin
               count_in      = count_ff - CW'(1);
               slot_in       = held_ff;
               slot_valid_in = 1'b1;
            end
            rpq_pkg::MODE_RELEASE: begin
               count_in      = count_ff + CW'(1);
               slot_in       = '0;
               slot_valid_in = 1'b0;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         slot_ff       <= '0;
         slot_valid_ff <= 1'b0;
         bytes_ff      <= '0;
         files_ff      <= '0;
         ok_ff         <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         count_ff      <= count_in;
         slot_ff       <= slot_in;
         slot_valid_ff <= slot_valid_in;
         bytes_ff      <= bytes_in;
         files_ff      <= files_in;
         if (cmd.lat_req) begin
            ok_ff <= 1'b0;
         end else if (cmd.set_ok) begin
            ok_ff <= 1'b1;
         end
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // result word
   assign out_sel = ok_ff && (req_ff.mode == rpq_pkg::MODE_ACQUIRE ||
                              req_ff.mode == rpq_pkg::MODE_READ);

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_ff.ok            <= ok_ff;
         rsp_ff.out_id        <= out_sel ? held_ff.id : '0;
         rsp_ff.out_size      <= out_sel ? held_ff.size : '0;
         rsp_ff.pending_count <= 7'(count_ff);
         rsp_ff.active_valid  <= slot_valid_ff;
         rsp_ff.active_id     <= slot_valid_ff ? slot_ff.id : '0;
         rsp_ff.bytes_held    <= bytes_ff;
         rsp_ff.files_held    <= files_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

/* rtl/reorderable_pending_queue.sv */
// top level of the reorderable pending queue
// ordered queue of (id, size) entries in a single-port-write, registered-read
// memory of DEPTH words, plus one active slot and running byte and file
// totals. one word is taken at a time. load and complete need no walk of the
// queue. a search by id walks from the head, each entry a memory read then
// a compare, and every entry shifted by a move, swap, remove, acquire or
// release is a read then a write-back through the one memory port. the
// result sits in an output register, so the next word is taken while it
// waits. entries at or beyond the pending count are never read, so the
// memory needs no clearing after reset
module reorderable_pending_queue #(
   parameter int DEPTH = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  rpq_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rpq_pkg::rsp_type rsp_data
);

   rpq_pkg::cmd_type cmd;
   rpq_pkg::sts_type sts;

   // sequencer
   rpq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // memory, counters and result register
   rpq_dp #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .sts       (sts)
   );

endmodule

/* rtl/rpq_checker.sv */
// port-level checker for the reorderable pending queue and its bind
`include "reorderable_pending_queue_assert.svh"

module rpq_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input rpq_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input rpq_pkg::rsp_type rsp_data
);

   // a waiting result holds
   `RPQ_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))
   // one word at a time
   `RPQ_ASSERT_NEXT(a_one_at_a_time, clock, reset, req_valid && req_ready, !req_ready)
   // empty slot shows a zero id
   `RPQ_ASSERT_SAME(a_slot_zero, clock, reset, rsp_valid && !rsp_data.active_valid, rsp_data.active_id == 64'd0)
   // rejected operations return no entry
   `RPQ_ASSERT_SAME(a_reject_zero, clock, reset, rsp_valid && !rsp_data.ok, rsp_data.out_id == 64'd0 && rsp_data.out_size == 48'd0)

endmodule

bind reorderable_pending_queue rpq_checker u_rpq_checker (.*);
